// ----- sv/bsc_pkg.sv -----
// Package for barometric compensation: result type, divider width and coefficient register indices.
// No dependencies.
package bsc_pkg;
   localparam int DivBits = 64;

   typedef struct packed {
      logic signed [31:0] fine_temperature;
      logic signed [31:0] temperature_centi;
      logic [31:0] pressure_pa;
      logic pressure_valid;
   } result_type;

   localparam logic [1:0] RegTemp = 2'd0;
   localparam logic [1:0] RegPressLow = 2'd1;
   localparam logic [1:0] RegPressMid = 2'd2;
   localparam logic [1:0] RegPressHigh = 2'd3;
endpackage

// ----- sv/bsc_mul64.sv -----
// Pipelined 64x64 -> low 64 multiplier built from 32-bit partial products.
// Depends on nothing.
module bsc_mul64 #(
   parameter int TagWidth = 1
) (
   input  logic                clock,
   input  logic                enable,
   input  logic [63:0]         a,
   input  logic [63:0]         b,
   input  logic [TagWidth-1:0] tag,
   output logic [63:0]         product,
   output logic [TagWidth-1:0] tag_out
);
   logic [63:0] ll_ff;
   logic [31:0] lh_ff, hl_ff;
   logic [TagWidth-1:0] tag_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         ll_ff <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
         lh_ff <= a[31:0] * b[63:32];
         hl_ff <= a[63:32] * b[31:0];
         tag_ff <= tag;
      end
   end

   assign product = ll_ff + {lh_ff + hl_ff, 32'd0};
   assign tag_out = tag_ff;
endmodule

// ----- sv/bsc_div.sv -----
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Depends on bsc_pkg.
module bsc_div
   import bsc_pkg::*;
#(
   parameter int TagWidth = 1
) (
   input  logic                clock,
   input  logic                enable,
   input  logic [63:0]         numer,
   input  logic [63:0]         denom,
   input  logic [TagWidth-1:0] tag,
   output logic [63:0]         quot,
   output logic [TagWidth-1:0] tag_out
);
   logic [63:0] rem_ff [DivBits+1];
   logic [63:0] num_ff [DivBits+1];
   logic [63:0] den_ff [DivBits+1];
   logic        neg_ff [DivBits+1];
   logic [TagWidth-1:0] tag_ff [DivBits+1];

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= '0;
         num_ff[0] <= numer[63] ? 64'd0 - numer : numer;
         den_ff[0] <= denom[63] ? 64'd0 - denom : denom;
         neg_ff[0] <= numer[63] ^ denom[63];
         tag_ff[0] <= tag;
      end
   end

   for (genvar i = 0; i < DivBits; i++) begin : g_step
      logic [64:0] trial;
      logic [64:0] diff;
      assign trial = {rem_ff[i], num_ff[i][63]};
      assign diff = trial - {1'b0, den_ff[i]};
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i+1] <= diff[64] ? trial[63:0] : diff[63:0];
            num_ff[i+1] <= {num_ff[i][62:0], ~diff[64]};
            den_ff[i+1] <= den_ff[i];
            neg_ff[i+1] <= neg_ff[i];
            tag_ff[i+1] <= tag_ff[i];
         end
      end
   end

   assign quot = neg_ff[DivBits] ? 64'd0 - num_ff[DivBits] : num_ff[DivBits];
   assign tag_out = tag_ff[DivBits];
endmodule

// ----- sv/barometric_sensor_compensation.sv -----
// Top level of barometric compensation: CSR port, pipeline, output register.
// Depends on bsc_pkg, bsc_mul64, bsc_div.
//
// One reading pair is accepted every clock while the output register is empty
// or taken. An item passes through 83 register stages in the pipeline: 6 front
// stages for the temperature path, 6 multiplier stages (64x64 low product from
// 32-bit partials, one register each), 5 product registers, 65 stages in the
// one-bit-per-stage divider and the output register. The whole pipeline
// advances together; it stalls only when the output register holds an item
// not yet taken. Coefficients are sampled as the item flows, so write them
// while idle.
module barometric_sensor_compensation
   import bsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // adc_pressure[19:0], adc_temperature[39:20]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [103:0] rsp_tdata, // fine_temperature, temperature_centi,
                                   // pressure_pa, pressure_valid (from bit 0 up)
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   logic [47:0] tc_ff, pl_ff, pm_ff, ph_ff;
   logic [1:0]  widx;
   assign widx = csr_paddr[4:3];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff <= '0; pl_ff <= '0; pm_ff <= '0; ph_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2:0] == 3'd0) begin
         case (widx)
            RegTemp:      tc_ff <= csr_pwdata[47:0];
            RegPressLow:  pl_ff <= csr_pwdata[47:0];
            RegPressMid:  pm_ff <= csr_pwdata[47:0];
            RegPressHigh: ph_ff <= csr_pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (widx)
         RegTemp:      csr_prdata = {16'd0, tc_ff};
         RegPressLow:  csr_prdata = {16'd0, pl_ff};
         RegPressMid:  csr_prdata = {16'd0, pm_ff};
         default:      csr_prdata = {16'd0, ph_ff};
      endcase
   end

   // coefficients, sign extended except t1 and p1, which are zero extended
   logic [31:0] t1, t2, t3;
   logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = {16'd0, tc_ff[15:0]};
   assign t2 = {{16{tc_ff[31]}}, tc_ff[31:16]};
   assign t3 = {{16{tc_ff[47]}}, tc_ff[47:32]};
   assign p1 = {48'd0, pl_ff[15:0]};
   assign p2 = {{48{pl_ff[31]}}, pl_ff[31:16]};
   assign p3 = {{48{pl_ff[47]}}, pl_ff[47:32]};
   assign p4 = {{48{pm_ff[15]}}, pm_ff[15:0]};
   assign p5 = {{48{pm_ff[31]}}, pm_ff[31:16]};
   assign p6 = {{48{pm_ff[47]}}, pm_ff[47:32]};
   assign p7 = {{48{ph_ff[15]}}, ph_ff[15:0]};
   assign p8 = {{48{ph_ff[31]}}, ph_ff[31:16]};
   assign p9 = {{48{ph_ff[47]}}, ph_ff[47:32]};

   // global pipeline advance; output register frees when taken
   logic adv;
   logic out_valid_ff;
   assign adv = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   // S0: input register
   logic        v0_ff;
   logic [19:0] adcp0_ff, adct0_ff;
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (adv) v0_ff <= req_tvalid;
      if (adv) begin
         adcp0_ff <= req_tdata[19:0];
         adct0_ff <= req_tdata[39:20];
      end
   end

   // S1: a, b
   logic        v1_ff;
   logic [19:0] adcp1_ff;
   logic [31:0] a1_ff, b1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= v0_ff;
      if (adv) begin
         adcp1_ff <= adcp0_ff;
         a1_ff <= {15'd0, adct0_ff[19:3]} - {t1[30:0], 1'b0};
         b1_ff <= {16'd0, adct0_ff[19:4]} - t1;
      end
   end

   // S2: a*t2, b*b
   logic        v2_ff;
   logic [19:0] adcp2_ff;
   logic [31:0] at2_ff, bb2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         adcp2_ff <= adcp1_ff;
         at2_ff <= a1_ff * t2;
         bb2_ff <= b1_ff * b1_ff;
      end
   end

   // S3: (bb>>>12)*t3 and (a*t2)>>>11
   logic        v3_ff;
   logic [19:0] adcp3_ff;
   logic [31:0] tv1_3_ff, bt3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         adcp3_ff <= adcp2_ff;
         tv1_3_ff <= 32'($signed(at2_ff) >>> 11);
         bt3_ff <= 32'($signed(bb2_ff) >>> 12) * t3;
      end
   end

   // S4: t_fine
   logic        v4_ff;
   logic [19:0] adcp4_ff;
   logic [31:0] tf4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
      if (adv) begin
         adcp4_ff <= adcp3_ff;
         tf4_ff <= tv1_3_ff + 32'($signed(bt3_ff) >>> 14);
      end
   end

   // S5: temperature, v1 = tf - 128000
   logic        v5_ff;
   logic [19:0] adcp5_ff;
   logic [31:0] tf5_ff, temp5_ff;
   logic [63:0] w5_ff;
   logic [31:0] t5x;
   assign t5x = tf4_ff * 32'd5 + 32'd128;
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
      if (adv) begin
         adcp5_ff <= adcp4_ff;
         tf5_ff <= tf4_ff;
         temp5_ff <= 32'($signed(t5x) >>> 8);
         w5_ff <= {{32{tf4_ff[31]}}, tf4_ff} - 64'd128000;
      end
   end

   // tag carried alongside multipliers: valid, adc_p, t_fine, temp, w
   localparam int TagA = 1 + 20 + 32 + 32 + 64;
   logic [TagA-1:0] tag5;
   assign tag5 = {v5_ff, adcp5_ff, tf5_ff, temp5_ff, w5_ff};

   // M1: w*w, w*p5, w*p2
   logic [63:0] ww, wp5, wp2;
   logic [TagA-1:0] tagm1;
   bsc_mul64 #(.TagWidth(TagA)) u_ww (.clock, .enable(adv), .a(w5_ff), .b(w5_ff),
      .tag(tag5), .product(ww), .tag_out(tagm1));
   bsc_mul64 #(.TagWidth(1)) u_wp5 (.clock, .enable(adv), .a(w5_ff), .b(p5),
      .tag(1'b0), .product(wp5), .tag_out());
   bsc_mul64 #(.TagWidth(1)) u_wp2 (.clock, .enable(adv), .a(w5_ff), .b(p2),
      .tag(1'b0), .product(wp2), .tag_out());

   // register products
   logic [63:0] ww_ff, wp5_ff, wp2_ff;
   logic [TagA-1:0] tag6_ff;
   always_ff @(posedge clock) begin
      if (reset) tag6_ff[TagA-1] <= 1'b0;
      else if (adv) tag6_ff[TagA-1] <= tagm1[TagA-1];
      if (adv) begin
         tag6_ff[TagA-2:0] <= tagm1[TagA-2:0];
         ww_ff <= ww; wp5_ff <= wp5; wp2_ff <= wp2;
      end
   end

   // M2: ww*p6, ww*p3
   logic [63:0] wwp6, wwp3;
   logic [TagA+128-1:0] tagm2;
   bsc_mul64 #(.TagWidth(TagA+128)) u_p6 (.clock, .enable(adv), .a(ww_ff), .b(p6),
      .tag({tag6_ff, wp5_ff, wp2_ff}), .product(wwp6), .tag_out(tagm2));
   bsc_mul64 #(.TagWidth(1)) u_p3 (.clock, .enable(adv), .a(ww_ff), .b(p3),
      .tag(1'b0), .product(wwp3), .tag_out());

   // S7: v2 sum and v1 partial
   logic [TagA-1:0] tag7_ff;
   logic [63:0] v2_7_ff, v1a_7_ff;
   logic [63:0] wp5_m, wp2_m;
   assign wp5_m = tagm2[127:64];
   assign wp2_m = tagm2[63:0];
   always_ff @(posedge clock) begin
      if (reset) tag7_ff[TagA-1] <= 1'b0;
      else if (adv) tag7_ff[TagA-1] <= tagm2[TagA+127];
      if (adv) begin
         tag7_ff[TagA-2:0] <= tagm2[TagA+126:128];
         v2_7_ff <= wwp6 + {wp5_m[46:0], 17'd0} + {p4[28:0], 35'd0};
         v1a_7_ff <= 64'($signed(wwp3) >>> 8) + {wp2_m[51:0], 12'd0};
      end
   end

   // M3: (2^47 + v1) * p1
   logic [63:0] v1p1;
   logic [TagA+64-1:0] tagm3;
   bsc_mul64 #(.TagWidth(TagA+64)) u_p1 (.clock, .enable(adv),
      .a(v1a_7_ff + 64'h0000_8000_0000_0000), .b(p1),
      .tag({tag7_ff, v2_7_ff}), .product(v1p1), .tag_out(tagm3));

   // S8: divisor, numerator base
   logic [TagA-1:0] tag8_ff;
   logic [63:0] den8_ff, nb8_ff;
   logic [63:0] adcpx;
   assign adcpx = 64'd1048576 - {44'd0, tagm3[TagA+64-2 -: 20]};
   always_ff @(posedge clock) begin
      if (reset) tag8_ff[TagA-1] <= 1'b0;
      else if (adv) tag8_ff[TagA-1] <= tagm3[TagA+63];
      if (adv) begin
         tag8_ff[TagA-2:0] <= tagm3[TagA+62:64];
         den8_ff <= 64'($signed(v1p1) >>> 33);
         nb8_ff <= {adcpx[32:0], 31'd0} - tagm3[63:0];
      end
   end

   // M4: numerator * 3125
   logic [63:0] num9;
   logic [TagA+64-1:0] tagm4;
   bsc_mul64 #(.TagWidth(TagA+64)) u_k (.clock, .enable(adv), .a(nb8_ff), .b(64'd3125),
      .tag({tag8_ff, den8_ff}), .product(num9), .tag_out(tagm4));

   logic [TagA+64-1:0] tag9_ff;
   logic [63:0] num9_ff;
   always_ff @(posedge clock) begin
      if (reset) tag9_ff[TagA+63] <= 1'b0;
      else if (adv) tag9_ff[TagA+63] <= tagm4[TagA+63];
      if (adv) begin
         tag9_ff[TagA+62:0] <= tagm4[TagA+62:0];
         num9_ff <= num9;
      end
   end

   // divider; tag keeps valid, t_fine, temp, divisor-nonzero flag
   localparam int TagD = 1 + 32 + 32 + 1;
   logic [63:0] q;
   logic [TagD-1:0] tagd;
   logic dvalid;
   bsc_div #(.TagWidth(TagD)) u_div (.clock, .enable(adv), .numer(num9_ff),
      .denom(tag9_ff[63:0]),
      .tag({tag9_ff[TagA+63], tag9_ff[64+127:64+64], tag9_ff[63:0] != 64'd0}),
      .quot(q), .tag_out(tagd));
   // valid bit through the divider stages is reset-cleared separately
   logic [DivBits:0] dv_ff;
   always_ff @(posedge clock) begin
      if (reset) dv_ff <= '0;
      else if (adv) dv_ff <= {dv_ff[DivBits-1:0], tag9_ff[TagA+63]};
   end
   assign dvalid = dv_ff[DivBits];

   // M5: p8*p, ps*ps
   logic [63:0] ps, p8p, psps;
   logic [TagD+64-1:0] tagm5;
   assign ps = 64'($signed(q) >>> 13);
   bsc_mul64 #(.TagWidth(TagD+64)) u_p8 (.clock, .enable(adv), .a(q), .b(p8),
      .tag({dvalid, tagd[TagD-2:0], q}), .product(p8p), .tag_out(tagm5));
   bsc_mul64 #(.TagWidth(1)) u_ps (.clock, .enable(adv), .a(ps), .b(ps),
      .tag(1'b0), .product(psps), .tag_out());

   logic [TagD+64-1:0] tag10_ff;
   logic [63:0] p8p_ff, psps_ff;
   always_ff @(posedge clock) begin
      if (reset) tag10_ff[TagD+63] <= 1'b0;
      else if (adv) tag10_ff[TagD+63] <= tagm5[TagD+63];
      if (adv) begin
         tag10_ff[TagD+62:0] <= tagm5[TagD+62:0];
         p8p_ff <= p8p; psps_ff <= psps;
      end
   end

   // M6: p9*ps*ps
   logic [63:0] p9pp;
   logic [TagD+128-1:0] tagm6;
   bsc_mul64 #(.TagWidth(TagD+128)) u_p9 (.clock, .enable(adv), .a(psps_ff), .b(p9),
      .tag({tag10_ff, p8p_ff}), .product(p9pp), .tag_out(tagm6));

   // S11: final sum
   logic [63:0] pf, p11;
   logic [63:0] pq;
   assign pq = tagm6[127:64];
   assign pf = pq + 64'($signed(p9pp) >>> 25) + 64'($signed(tagm6[63:0]) >>> 19);
   assign p11 = 64'($signed(pf) >>> 8) + {p7[59:0], 4'd0};

   result_type res_ff;
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= tagm6[TagD+127];
      if (adv) begin
         res_ff.fine_temperature <= tagm6[128+64 -: 32];
         res_ff.temperature_centi <= tagm6[128+32 -: 32];
         res_ff.pressure_valid <= tagm6[128];
         res_ff.pressure_pa <= tagm6[128] ? p11[39:8] : 32'd0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {7'd0, res_ff.pressure_valid, res_ff.pressure_pa,
                       res_ff.temperature_centi, res_ff.fine_temperature};
endmodule

// ----- sv/bsc_checker.sv -----
// Port-level checker for barometric compensation, bound to the top level.
// Depends on barometric_sensor_compensation ports only.
module bsc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [103:0] rsp_tdata,
   input logic         csr_pready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[103:97] == 7'd0 && (rsp_tdata[96] || rsp_tdata[95:64] == 32'd0))
      else $error("invalid pressure not zero");
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_pready);

// ----- tb/sv/tb.sv -----
// Self-checking bench for barometric_sensor_compensation: stream and CSR stimulus,
// a bit-exact compensation predictor and an in-order result checker.
// Depends on bsc_pkg and the barometric_sensor_compensation RTL.
module tb
   import bsc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [39:0]  req_tdata = '0;   // adc_pressure[19:0], adc_temperature[39:20]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;        // fine_temperature, temperature_centi,
                                   // pressure_pa, pressure_valid (from bit 0 up)
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [63:0]  csr_pwdata = '0;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   // bench copy of the coefficient registers, indexed like the CSR map
   bit [47:0]    coeff_reg [4];
   logic [39:0]  pending_readings [$];
   result_type   expected_results [$];
   int           mismatches = 0;
   int           send_idle_pct = 18;
   int           recv_idle_pct = 49;

   barometric_sensor_compensation DUT (.*);

   always #5 clock = ~clock;

   function automatic bit [63:0] sx16(bit [47:0] r, int pos);
      bit [15:0] v;
      v = r[pos +: 16];
      return {{48{v[15]}}, v};
   endfunction

   // integer compensation: 32-bit wrapping temperature path, 64-bit pressure path
   function automatic result_type compensate(bit [19:0] adc_p, bit [19:0] adc_t);
      bit [31:0] t1, t2, t3, a, b, tv1, tv2, t32, t_fine, centi;
      bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      bit [63:0] v1, v2, den, tmp, num, an, ad, quo, ps, w1, w2;
      bit        nneg, dneg;
      result_type r;
      t1 = {16'd0, coeff_reg[RegTemp][15:0]};
      t2 = sx16(coeff_reg[RegTemp], 16);
      t3 = sx16(coeff_reg[RegTemp], 32);
      p1 = {48'd0, coeff_reg[RegPressLow][15:0]};
      p2 = sx16(coeff_reg[RegPressLow], 16);
      p3 = sx16(coeff_reg[RegPressLow], 32);
      p4 = sx16(coeff_reg[RegPressMid], 0);
      p5 = sx16(coeff_reg[RegPressMid], 16);
      p6 = sx16(coeff_reg[RegPressMid], 32);
      p7 = sx16(coeff_reg[RegPressHigh], 0);
      p8 = sx16(coeff_reg[RegPressHigh], 16);
      p9 = sx16(coeff_reg[RegPressHigh], 32);

      a = ({12'd0, adc_t} >> 3) - (t1 << 1);
      tv1 = $signed(a * t2) >>> 11;
      b = ({12'd0, adc_t} >> 4) - t1;
      t32 = $signed(b * b) >>> 12;
      tv2 = $signed(t32 * t3) >>> 14;
      t_fine = tv1 + tv2;
      centi = $signed(t_fine * 32'd5 + 32'd128) >>> 8;

      v1 = {{32{t_fine[31]}}, t_fine} - 64'd128000;
      v2 = v1 * v1 * p6 + ((v1 * p5) << 17) + (p4 << 35);
      tmp = $signed(v1 * v1 * p3) >>> 8;
      den = tmp + ((v1 * p2) << 12);
      tmp = ((64'd1 << 47) + den) * p1;
      den = $signed(tmp) >>> 33;

      r.fine_temperature = t_fine;
      r.temperature_centi = centi;
      r.pressure_pa = '0;
      r.pressure_valid = 1'b0;
      if (den != 0) begin
         num = (((64'd1048576 - {44'd0, adc_p}) << 31) - v2) * 64'd3125;
         // truncating signed divide on magnitudes; min / -1 wraps to min
         nneg = num[63];
         dneg = den[63];
         an = nneg ? -num : num;
         ad = dneg ? -den : den;
         quo = an / ad;
         if (nneg != dneg) quo = -quo;
         ps = $signed(quo) >>> 13;
         w1 = $signed(p9 * ps * ps) >>> 25;
         w2 = $signed(p8 * quo) >>> 19;
         tmp = quo + w1 + w2;
         tmp = $signed(tmp) >>> 8;
         tmp = tmp + (p7 << 4);
         tmp = $signed(tmp) >>> 8;
         r.pressure_pa = tmp[31:0];
         r.pressure_valid = 1'b1;
      end
      return r;
   endfunction

   // driver: predict on acceptance, then present the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(compensate(req_tdata[19:0], req_tdata[39:20]));
         if (!req_tvalid || req_tready) begin
            if (pending_readings.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tdata <= pending_readings.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            // tdata carries fine_temperature in the lowest bits
            got.fine_temperature = rsp_tdata[31:0];
            got.temperature_centi = rsp_tdata[63:32];
            got.pressure_pa = rsp_tdata[95:64];
            got.pressure_valid = rsp_tdata[96];
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result item %h", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("exp ft=%0d tc=%0d p=%0d v=%0b, got ft=%0d tc=%0d p=%0d v=%0b",
                        want.fine_temperature, want.temperature_centi, want.pressure_pa,
                        want.pressure_valid, got.fine_temperature, got.temperature_centi,
                        got.pressure_pa, got.pressure_valid);
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // setup + access cycle; the register takes the value at the access edge
   task automatic csr_write(logic [1:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      coeff_reg[idx] = val[47:0];   // upper bits are dropped
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic write_coeffs(logic [63:0] tc, logic [63:0] pl, logic [63:0] pm,
                               logic [63:0] ph);
      csr_write(RegTemp, tc);
      csr_write(RegPressLow, pl);
      csr_write(RegPressMid, pm);
      csr_write(RegPressHigh, ph);
   endtask

   // let the pipeline drain fully before touching CSRs
   task automatic drain();
      while (pending_readings.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // typical factory calibration with optional jitter on every term
   function automatic logic [15:0] jit(int base, bit on);
      return on ? 16'(base + $urandom_range(0, 400) - 200) : 16'(base);
   endfunction

   task automatic typical_coeffs(bit on);
      write_coeffs({16'($urandom), jit(-1000, on), jit(26435, on), jit(27504, on)},
                   {16'($urandom), jit(3024, on), jit(-10685, on), jit(36477, on)},
                   {16'h0, jit(-7, on), jit(140, on), jit(2855, on)},
                   {16'h0, jit(6000, on), jit(-14600, on), jit(15500, on)});
   endtask

   task automatic directed_readings();
      logic [19:0] corner [8] = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF,
                                  20'hAAAAA, 20'h55555, 20'd415148, 20'd519888};
      for (int i = 0; i < 8; i++)
         pending_readings.push_back({corner[i], corner[7 - i]});
      pending_readings.push_back({20'd519888, 20'd415148});
      pending_readings.push_back({20'd500000, 20'd300000});
   endtask

   task automatic random_readings(int n);
      logic [19:0] ap, at;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: ap = 20'h00000;
            1: ap = 20'hFFFFF;
            2, 3: ap = 20'($urandom_range(200000, 600000));
            default: ap = 20'($urandom_range(0, 20'hFFFFF));
         endcase
         case ($urandom_range(9))
            0: at = 20'h00000;
            1: at = 20'hFFFFF;
            2, 3, 4: at = 20'($urandom_range(400000, 600000));
            default: at = 20'($urandom_range(0, 20'hFFFFF));
         endcase
         pending_readings.push_back({at, ap});
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset coefficients: zero divisor, pressure must read invalid
      directed_readings();
      drain();
      typical_coeffs(1'b0);
      directed_readings();
      drain();

      for (int k = 0; k < 9; k++) begin
         send_idle_pct = (k < 3) ? 18 : (k < 6) ? 49 : 0;
         recv_idle_pct = (k < 3) ? 49 : (k < 6) ? 18 : 0;
         case (k)
            0: write_coeffs('1, '1, '1, '1);
            1: write_coeffs(64'h7FFF_7FFF_7FFF, 64'h7FFF_7FFF_FFFF,
                            64'h7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF);
            2: write_coeffs(64'h8000_8000_0000, 64'h8000_8000_0001,
                            64'h8000_8000_8000, 64'h8000_8000_8000);
            4, 7: write_coeffs({$urandom, $urandom}, {$urandom, $urandom},
                               {$urandom, $urandom}, {$urandom, $urandom});
            default: typical_coeffs(1'b1);
         endcase
         if (k < 3) directed_readings();
         random_readings(89);
         drain();
      end

      if (mismatches == 0)
         $display("barometric_sensor_compensation regression: pass");
      else
         $display("barometric_sensor_compensation regression: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("barometric_sensor_compensation regression: fail");
      $finish;
   end
endmodule
